// File: hw/rtl/spq_pkg.sv
package spq_pkg;

  localparam int DefQueueDepth = 16;
  localparam int TagW          = 8;
  localparam int PrioW         = 8;
  localparam int EntryCntW     = 5;
  localparam int InDataW       = 16;
  localparam int OutDataW      = 24;

  typedef enum logic [0:0] {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } spq_mode_t;

  // Request broadcast to every slot cell.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [PrioW-1:0] prio;
    logic [TagW-1:0]  tag;
  } spq_ctrl_t;

endpackage

// File: hw/rtl/spq_cell.sv
module spq_cell (
  input  logic                      clk,
  input  spq_pkg::spq_ctrl_t        ctrl,
  input  logic                      occ,
  input  logic                      prev_ge,
  input  logic [spq_pkg::PrioW-1:0] prev_prio,
  input  logic [spq_pkg::TagW-1:0]  prev_tag,
  input  logic [spq_pkg::PrioW-1:0] next_prio,
  input  logic [spq_pkg::TagW-1:0]  next_tag,
  output logic [spq_pkg::PrioW-1:0] prio,
  output logic [spq_pkg::TagW-1:0]  tag,
  output logic                      ge
);
  import spq_pkg::*;

  logic [PrioW-1:0] prio_r, prio_nxt;
  logic [TagW-1:0]  tag_r, tag_nxt;

  // Entry stays ahead of a new one with equal or lower priority.
  assign ge = occ && (prio_r >= ctrl.prio);

  always_comb begin
    prio_nxt = prio_r;
    tag_nxt  = tag_r;
    if (ctrl.ins) begin
      if (!ge) begin
        if (prev_ge) begin
          prio_nxt = ctrl.prio;
          tag_nxt  = ctrl.tag;
        end else begin
          prio_nxt = prev_prio;
          tag_nxt  = prev_tag;
        end
      end
    end else if (ctrl.rem) begin
      prio_nxt = next_prio;
      tag_nxt  = next_tag;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

  assign prio = prio_r;
  assign tag  = tag_r;

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// Output: each accepted request's result is registered in the output register.
// Throughput: one request per cycle; every slot cell compares and shifts in parallel,
// so the only stall is a result still waiting in the output register.
// Reset: clears the entry count and the output valid flag; the output data register and
// slot contents are not cleared, and slots are only read below the entry count.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::DefQueueDepth
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [spq_pkg::InDataW-1:0]  in_tdata,   // entry_tag[7:0], entry_priority[15:8]
  input  logic                         in_tuser,   // mode
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // out_valid[0], out_tag[8:1], out_priority[16:9], dropped[17],
  // entry_count[22:18], is_empty[23]
  output logic [spq_pkg::OutDataW-1:0] out_tdata
);
  import spq_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0]     count_r, count_nxt;
  logic                out_tvalid_r;
  logic [OutDataW-1:0] out_tdata_r, out_tdata_nxt;

  logic                accept, is_rem, full, empty;
  spq_ctrl_t           ctrl;

  logic [PrioW-1:0]    cell_prio [QUEUE_DEPTH];
  logic [TagW-1:0]     cell_tag  [QUEUE_DEPTH];
  logic                cell_ge   [QUEUE_DEPTH];

  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_rem    = (spq_mode_t'(in_tuser) == MODE_REMOVE);
  assign full      = (count_r == CntW'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);

  always_comb begin
    ctrl.ins  = accept && !is_rem && !full;
    ctrl.rem  = accept && is_rem && !empty;
    ctrl.tag  = in_tdata[TagW-1:0];
    ctrl.prio = in_tdata[TagW+PrioW-1:TagW];
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             occ, prev_ge;
    logic [PrioW-1:0] prev_prio, next_prio;
    logic [TagW-1:0]  prev_tag, next_tag;

    assign occ = (count_r > CntW'(i));

    if (i == 0) begin : g_first
      assign prev_ge   = 1'b1;
      assign prev_prio = '0;
      assign prev_tag  = '0;
    end else begin : g_mid
      assign prev_ge   = cell_ge[i-1];
      assign prev_prio = cell_prio[i-1];
      assign prev_tag  = cell_tag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_prio = '0;
      assign next_tag  = '0;
    end else begin : g_inner
      assign next_prio = cell_prio[i+1];
      assign next_tag  = cell_tag[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ),
      .prev_ge   (prev_ge),
      .prev_prio (prev_prio),
      .prev_tag  (prev_tag),
      .next_prio (next_prio),
      .next_tag  (next_tag),
      .prio      (cell_prio[i]),
      .tag       (cell_tag[i]),
      .ge        (cell_ge[i])
    );
  end

  always_comb begin
    logic            r_valid, r_drop;
    logic [CntW-1:0] cnt;
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CntW'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - CntW'(1);
    end
    r_valid = ctrl.rem;
    r_drop  = accept && !is_rem && full;
    cnt     = count_nxt;
    out_tdata_nxt = {(cnt == '0),
                     EntryCntW'(cnt),
                     r_drop,
                     r_valid ? cell_prio[0] : {PrioW{1'b0}},
                     r_valid ? cell_tag[0]  : {TagW{1'b0}},
                     r_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_remove_dec : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_rem && !empty) |=> (count_r == $past(count_r) - CntW'(1)))
    else $error("remove did not decrement count");

  a_full_drop : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_rem && full) |=> (count_r == $past(count_r) && out_tdata_r[17]))
    else $error("insert on full queue not dropped");

  a_empty_flag : assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept) |-> (out_tdata_r[23] == (count_r == '0)))
    else $error("empty flag disagrees with count");

endmodule
